FILE: sv/bcdm_pkg.sv
package bcdm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int GAIN_W   = 16;
  localparam int DEPTH_W  = 5;
  localparam int FACTOR_W = 8;
  localparam int LEVEL_W  = 16;

  localparam int DEPTH_MAX = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DS_FACTOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_LEVEL  = 3'd4;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd4096;
  localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 5'd24;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd1;
  localparam logic [LEVEL_W-1:0]  DRY_RST    = 16'd0;
  localparam logic [LEVEL_W-1:0]  WET_RST    = 16'd32768;

  typedef enum logic [1:0] {
    MUL_GAIN,
    MUL_DRY,
    MUL_WET
  } mul_sel_t;

  typedef struct packed {
    logic     load_x;
    mul_sel_t mul_sel;
    logic     prod_load;
    logic     hold_step;
    logic     acc_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/bcdm_ctrl.sv
module bcdm_ctrl
  import bcdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAIN,
    S_DRY,
    S_WET,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  always_comb begin
    in_stall = !((state_r == S_IDLE) || ((state_r == S_FIN) && status.out_free));
    accept   = in_valid && !in_stall;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_GAIN;
      end
      S_GAIN: state_nxt = S_DRY;
      S_DRY:  state_nxt = S_WET;
      S_WET:  state_nxt = S_FIN;
      S_FIN: begin
        if (status.out_free) state_nxt = accept ? S_GAIN : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load_x    = accept;
    cmd.prod_load = (state_r inside {S_GAIN, S_DRY, S_WET});
    cmd.hold_step = (state_r == S_DRY);
    cmd.acc_load  = (state_r == S_WET);
    cmd.out_load  = (state_r == S_FIN) && status.out_free;
    case (state_r)
      S_GAIN:  cmd.mul_sel = MUL_GAIN;
      S_DRY:   cmd.mul_sel = MUL_DRY;
      S_WET:   cmd.mul_sel = MUL_WET;
      default: cmd.mul_sel = MUL_GAIN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/bcdm_datapath.sv
module bcdm_datapath
  import bcdm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  dp_cmd_t                        cmd,
  output dp_status_t                     status
);

  localparam int F   = SAMPLE_WIDTH - 1;
  localparam int HW  = SAMPLE_WIDTH + 4;
  localparam int CW  = SAMPLE_WIDTH + 5;
  localparam int PW  = CW + LEVEL_W + 1;
  localparam int AW  = PW + 1;
  localparam int RW  = AW - 15;
  localparam int SHW = $clog2(SAMPLE_WIDTH);

  localparam logic signed [RW-1:0] MAXV = RW'((64'd1 << F) - 64'd1);
  localparam logic signed [RW-1:0] MINV = ~MAXV;

  logic [GAIN_W-1:0]   gain_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic [FACTOR_W-1:0] factor_r;
  logic [LEVEL_W-1:0]  dry_r;
  logic [LEVEL_W-1:0]  wet_r;

  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [HW-1:0]           held_r;
  logic [FACTOR_W-1:0]            count_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [AW-1:0]           acc_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;
  logic                           out_valid_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      depth_r  <= DEPTH_RST;
      factor_r <= FACTOR_RST;
      dry_r    <= DRY_RST;
      wet_r    <= WET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_GAIN: gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_BIT_DEPTH:  depth_r  <= cfg_data[DEPTH_W-1:0];
        CFG_DS_FACTOR:  factor_r <= cfg_data[FACTOR_W-1:0];
        CFG_DRY_LEVEL:  dry_r    <= cfg_data[LEVEL_W-1:0];
        CFG_WET_LEVEL:  wet_r    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // quantizer on the held value
  logic [DEPTH_W-1:0]   depth_eff;
  logic                 depth_pass;
  logic [5:0]           shift6;
  logic [SHW-1:0]       shift;
  logic signed [CW-1:0] held_ext;
  logic signed [CW-1:0] half;
  logic signed [CW-1:0] crush_sum;
  logic signed [CW-1:0] crushed;

  always_comb begin
    if (depth_r == '0) begin
      depth_eff = DEPTH_W'(1);
    end else if (depth_r > DEPTH_W'(DEPTH_MAX)) begin
      depth_eff = DEPTH_W'(DEPTH_MAX);
    end else begin
      depth_eff = depth_r;
    end
    depth_pass = ({1'b0, depth_eff} >= 6'(F));
    shift6     = 6'(F) - {1'b0, depth_eff};
    shift      = shift6[SHW-1:0];
    held_ext   = CW'(held_r);
    half       = CW'(1) << (shift - SHW'(1));
    crush_sum  = held_ext + (held_r[HW-1] ? (half - CW'(1)) : half);
    if (depth_pass) begin
      crushed = held_ext;
    end else begin
      crushed = crush_sum & ~((CW'(1) << shift) - CW'(1));
    end
  end

  // shared multiplier
  logic signed [CW-1:0]      mul_a;
  logic signed [LEVEL_W:0]   mul_b;
  logic signed [PW-1:0]      mul_p;

  always_comb begin
    case (cmd.mul_sel)
      MUL_GAIN: begin
        mul_a = CW'(x_r);
        mul_b = {1'b0, gain_r};
      end
      MUL_DRY: begin
        mul_a = CW'(x_r);
        mul_b = {1'b0, dry_r};
      end
      MUL_WET: begin
        mul_a = crushed;
        mul_b = {1'b0, wet_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // gain rounding and hold counter
  logic signed [PW-1:0] gain_sum;
  logic signed [HW-1:0] gained;
  logic [FACTOR_W:0]    count_inc;
  logic                 capture;

  always_comb begin
    gain_sum  = prod_r + (prod_r[PW-1] ? PW'(2047) : PW'(2048));
    gained    = gain_sum[HW+11:12];
    count_inc = {1'b0, count_r} + (FACTOR_W+1)'(1);
    capture   = (count_inc >= {1'b0, factor_r});
  end

  // final mix, rounding and saturation
  logic signed [AW-1:0] mix_sum;
  logic signed [AW-1:0] mix_rnd;
  logic signed [RW-1:0] mix_q;
  logic signed [SAMPLE_WIDTH-1:0] mix_sat;

  always_comb begin
    mix_sum = acc_r + AW'(prod_r);
    mix_rnd = mix_sum + (mix_sum[AW-1] ? AW'(16383) : AW'(16384));
    mix_q   = mix_rnd[AW-1:15];
    if (mix_q > MAXV) begin
      mix_sat = MAXV[SAMPLE_WIDTH-1:0];
    end else if (mix_q < MINV) begin
      mix_sat = MINV[SAMPLE_WIDTH-1:0];
    end else begin
      mix_sat = mix_q[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_load) prod_r <= mul_p;
    if (cmd.load_x) x_r <= in_sample_in;
    if (cmd.acc_load) acc_r <= AW'(prod_r);
    if (cmd.out_load) out_r <= mix_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.hold_step) begin
        if (capture) begin
          held_r  <= gained;
          count_r <= '0;
        end else begin
          count_r <= count_inc[FACTOR_W-1:0];
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_r;

endmodule

FILE: sv/bitcrusher_downsample_mix_unit.sv
// A single shared multiplier takes the gain, dry and wet products in turn in
// states S_GAIN, S_DRY and S_WET; in S_FIN the mix is rounded and saturated.
// A new input word is accepted only while idle or as the previous word leaves
// S_FIN; a word waiting at the output holds back the next word in S_FIN.
// Reset: synchronous, active low; registers return to defaults, hold state clears.
module bitcrusher_downsample_mix_unit
  import bcdm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bcdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bcdm_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status)
  );

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous word in flight");

  a_hold_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hold_step |-> $past(in_valid && !in_stall, 2))
    else $error("hold update without matching input word");

  a_wet_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_load |-> $past(cmd.hold_step))
    else $error("wet product out of sequence");

  a_out_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("finished word not presented");
`endif

endmodule
